>>> src/spq_pkg.sv
// Shared types and constants for the stable priority task queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;

    localparam int HANDLE_W   = 16;
    localparam int ARGUMENT_W = 32;
    localparam int PRIORITY_W = 10;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;

    // running priority while the queue is idle
    localparam logic [PRIORITY_W-1:0] IDLE_PRIORITY = PRIORITY_W'(999);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_POP     = 2'd1,
        ACT_FINISH  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [ARGUMENT_W-1:0] argument;
        logic [PRIORITY_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_POP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/spq_store.sv
// Entry store: single write port, single registered read port.
// Depends on spq_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module spq_store #(
    parameter int DEPTH  = spq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic [spq_pkg::ENTRY_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    output      logic [spq_pkg::ENTRY_W-1:0] rd_data
);
    import spq_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/spq_ctrl.sv
// Queue controller: sequencer, circular head/count, sorted insert walk,
// running state and the result register. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
    parameter int DEPTH  = spq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // task channel
    input  wire logic                          task_valid,
    output      logic                          task_stall,
    input  wire logic [spq_pkg::ACTION_W-1:0]  action,
    input  wire logic [spq_pkg::HANDLE_W-1:0]  task_handle,
    input  wire logic [spq_pkg::ARGUMENT_W-1:0] task_argument,
    input  wire logic [spq_pkg::PRIORITY_W-1:0] task_priority,
    // result channel
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic [spq_pkg::STATUS_W-1:0]  status,
    output      logic [spq_pkg::HANDLE_W-1:0]  popped_handle,
    output      logic [spq_pkg::ARGUMENT_W-1:0] popped_argument,
    output      logic [spq_pkg::PRIORITY_W-1:0] popped_priority,
    output      logic                          preempt,
    // store port
    output      logic                          wr_en,
    output      logic [ADDR_W-1:0]             wr_addr,
    output      logic [spq_pkg::ENTRY_W-1:0]   wr_data,
    output      logic                          rd_en,
    output      logic [ADDR_W-1:0]             rd_addr,
    input  wire logic [spq_pkg::ENTRY_W-1:0]   rd_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    entry_t                 item_reg, item_next;
    logic                   running_reg, running_next;
    logic [PRIORITY_W-1:0]  run_prio_reg, run_prio_next;

    // pending result
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    entry_t                 res_entry_reg, res_entry_next;
    logic                   res_preempt_reg, res_preempt_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    entry_t                 out_entry_reg, out_entry_next;
    logic                   out_preempt_reg, out_preempt_next;

    entry_t                 rd_entry;
    logic                   out_free;
    logic                   task_accept;

    // logical position -> physical slot of the circular store
    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign rd_entry    = entry_t'(rd_data);
    assign out_free    = !out_valid_reg || !result_stall;
    assign task_stall  = (state_reg != S_IDLE);
    assign task_accept = task_valid && (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (task_valid)
                begin
                    if (action == ACT_ENQUEUE && count_reg != CNT_W'(DEPTH))
                    begin
                        state_next = S_INS_RD;
                    end
                    else if (action == ACT_POP && count_reg != '0)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = (pos_reg == '0) ? S_DONE : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                state_next = (rd_entry.prio > item_reg.prio) ? S_INS_RD : S_DONE;
            end
            S_POP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and store requests
    always_comb
    begin
        count_next       = count_reg;
        head_next        = head_reg;
        pos_next         = pos_reg;
        item_next        = item_reg;
        running_next     = running_reg;
        run_prio_next    = run_prio_reg;
        res_status_next  = res_status_reg;
        res_entry_next   = res_entry_reg;
        res_preempt_next = res_preempt_reg;

        out_valid_next   = out_valid_reg && result_stall;
        out_status_next  = out_status_reg;
        out_entry_next   = out_entry_reg;
        out_preempt_next = out_preempt_reg;

        wr_en   = 1'b0;
        wr_addr = slot_addr(head_reg, pos_reg);
        wr_data = ENTRY_W'(item_reg);
        rd_en   = 1'b0;
        rd_addr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (task_accept)
                begin
                    item_next        = '{handle: task_handle, argument: task_argument,
                                         prio: task_priority};
                    pos_next         = count_reg;
                    res_status_next  = ST_OK;
                    res_entry_next   = '0;
                    res_preempt_next = 1'b0;
                    case (action)
                        ACT_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_preempt_next = running_reg &&
                                                   (task_priority < run_prio_reg);
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = head_reg;
                            end
                        end
                        ACT_FINISH:
                        begin
                            running_next  = 1'b0;
                            run_prio_next = IDLE_PRIORITY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    // new entry goes to the head
                    wr_en      = 1'b1;
                    wr_addr    = slot_addr(head_reg, pos_reg);
                    wr_data    = ENTRY_W'(item_reg);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot_addr(head_reg, pos_reg - 1'b1);
                end
            end
            S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_addr(head_reg, pos_reg);
                if (rd_entry.prio > item_reg.prio)
                begin
                    // shift the less urgent entry one slot back
                    wr_data  = rd_data;
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    wr_data    = ENTRY_W'(item_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            S_POP:
            begin
                res_entry_next = rd_entry;
                running_next   = 1'b1;
                run_prio_next  = rd_entry.prio;
                count_next     = count_reg - 1'b1;
                head_next      = slot_addr(head_reg, CNT_W'(1));
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_entry_next   = res_entry_reg;
                    out_preempt_next = res_preempt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            running_reg   <= 1'b0;
            run_prio_reg  <= IDLE_PRIORITY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            running_reg   <= running_next;
            run_prio_reg  <= run_prio_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        item_reg        <= item_next;
        res_status_reg  <= res_status_next;
        res_entry_reg   <= res_entry_next;
        res_preempt_reg <= res_preempt_next;
        out_status_reg  <= out_status_next;
        out_entry_reg   <= out_entry_next;
        out_preempt_reg <= out_preempt_next;
    end

    assign result_valid    = out_valid_reg;
    assign status          = out_status_reg;
    assign popped_handle   = out_entry_reg.handle;
    assign popped_argument = out_entry_reg.argument;
    assign popped_priority = out_entry_reg.prio;
    assign preempt         = out_preempt_reg;

endmodule

`default_nettype wire

>>> src/stable_priority_task_queue_core.sv
// Stable priority task queue. An accepted transaction goes from idle straight to done for
// finish, full, empty or unused codes and through the pop state for a pop; an enqueue that
// moves past less urgent entries alternates read and compare, then writes itself and is done.
// One transaction at a time: the next one is taken the cycle after the result is registered;
// the insert walk reads a store entry, then compares and rewrites it (registered read port).
// Reset (rst_n, async low) empties the queue and sets it idle with running priority 999.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_task_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // task channel
    input  wire logic                          task_valid,
    output      logic                          task_stall,
    input  wire logic [spq_pkg::ACTION_W-1:0]  action,
    input  wire logic [spq_pkg::HANDLE_W-1:0]  task_handle,
    input  wire logic [spq_pkg::ARGUMENT_W-1:0] task_argument,
    input  wire logic [spq_pkg::PRIORITY_W-1:0] task_priority,
    // result channel
    output      logic                          result_valid,
    input  wire logic                          result_stall,
    output      logic [spq_pkg::STATUS_W-1:0]  status,
    output      logic [spq_pkg::HANDLE_W-1:0]  popped_handle,
    output      logic [spq_pkg::ARGUMENT_W-1:0] popped_argument,
    output      logic [spq_pkg::PRIORITY_W-1:0] popped_priority,
    output      logic                          preempt
);
    import spq_pkg::*;

    // slot index width of the circular entry store
    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    // Controller: keeps head/count of the circular store, runs the sorted
    // insert from the tail toward the head (stops behind equal priorities,
    // so ties leave in arrival order), pops by advancing the head, and
    // holds the result register so a finished result can wait on the
    // result channel while the next transaction is taken.
    spq_ctrl #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .task_valid      (task_valid),
        .task_stall      (task_stall),
        .action          (action),
        .task_handle     (task_handle),
        .task_argument   (task_argument),
        .task_priority   (task_priority),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .popped_handle   (popped_handle),
        .popped_argument (popped_argument),
        .popped_priority (popped_priority),
        .preempt         (preempt),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

    // Entry store: only slots inside the live window are ever read, so it
    // needs no clearing after reset.
    spq_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for stable_priority_task_queue_core: directed and random task traffic.
// Each transaction is run through a local model of the queue. Every result is checked in order.
// Depends on spq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH;
    localparam int LONG_HOLD      = 150;    // cycles of result hold-off under pressure
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transaction
    localparam int SETTLE_CYCLES  = 40;     // longest enqueue walk with margin

    // action code 3 is not decoded by the block
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // action mixes for the random traffic
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [HANDLE_W-1:0]   handle;
        logic [ARGUMENT_W-1:0] argument;
        logic [PRIORITY_W-1:0] prio;
        logic                  preempt;
    } queue_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  task_valid;
    logic                  task_stall;
    logic [ACTION_W-1:0]   action;
    logic [HANDLE_W-1:0]   task_handle;
    logic [ARGUMENT_W-1:0] task_argument;
    logic [PRIORITY_W-1:0] task_priority;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   popped_handle;
    logic [ARGUMENT_W-1:0] popped_argument;
    logic [PRIORITY_W-1:0] popped_priority;
    logic                  preempt;

    // local copy of the queue contents and run state
    entry_t                model_store [QUEUE_DEPTH];
    int                    model_count = 0;
    logic [PRIORITY_W-1:0] model_run_prio = IDLE_PRIORITY;
    logic                  model_running = 1'b0;

    queue_outcome_t pending_outcomes[$];
    queue_outcome_t next_expected;
    int             error_count = 0;
    int             quiet_cycles = 0;

    // long hold-off requests from the test sequence, served by the stall process
    int             hold_requested = 0;
    int             hold_served = 0;
    int             hold_left = 0;
    int             stall_mode = 0;
    logic [5:0]     stall_phase = '0;

    always #1 clk = ~clk;

    stable_priority_task_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .task_valid      (task_valid),
        .task_stall      (task_stall),
        .action          (action),
        .task_handle     (task_handle),
        .task_argument   (task_argument),
        .task_priority   (task_priority),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .popped_handle   (popped_handle),
        .popped_argument (popped_argument),
        .popped_priority (popped_priority),
        .preempt         (preempt)
    );

    // ------------------------------------------------------------------
    // Queue model: applies one accepted transaction and returns its result.
    // Insert goes behind every entry of equal or more urgent priority, which
    // keeps equal priorities in arrival order.
    // ------------------------------------------------------------------
    function automatic queue_outcome_t predict_queue_outcome(input logic [ACTION_W-1:0] act,
                                                             input entry_t item);
        queue_outcome_t res;
        entry_t         head;
        int             slot;
        res = '{status: ST_OK, handle: '0, argument: '0, prio: '0, preempt: 1'b0};
        case (act)
            ACT_ENQUEUE:
            begin
                if (model_count >= QUEUE_DEPTH)
                    res.status = ST_FULL;   // dropped, state untouched
                else
                begin
                    slot = 0;
                    while (slot < model_count && model_store[slot].prio <= item.prio)
                        slot++;
                    for (int i = model_count; i > slot; i--)
                        model_store[i] = model_store[i-1];
                    model_store[slot] = item;
                    model_count++;
                    res.preempt = model_running && (item.prio < model_run_prio);
                end
            end
            ACT_POP:
            begin
                if (model_count == 0)
                    res.status = ST_EMPTY;  // run state kept as is
                else
                begin
                    head = model_store[0];
                    for (int i = 1; i < model_count; i++)
                        model_store[i-1] = model_store[i];
                    model_count--;
                    model_run_prio = head.prio;
                    model_running  = 1'b1;
                    res.handle   = head.handle;
                    res.argument = head.argument;
                    res.prio     = head.prio;
                end
            end
            ACT_FINISH:
            begin
                model_run_prio = IDLE_PRIORITY;
                model_running  = 1'b0;
            end
            default: ;  // unused code: no effect, all-zero result
        endcase
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Sender side. Tasks are entered in the time step of a rising edge.
    // ------------------------------------------------------------------
    task automatic offer_transaction(input logic [ACTION_W-1:0]   act,
                                     input logic [HANDLE_W-1:0]   handle,
                                     input logic [ARGUMENT_W-1:0] argument,
                                     input logic [PRIORITY_W-1:0] prio_val);
        entry_t item;
        item.handle   = handle;
        item.argument = argument;
        item.prio     = prio_val;
        task_valid    <= 1'b1;
        action        <= act;
        task_handle   <= handle;
        task_argument <= argument;
        task_priority <= prio_val;
        // values read here are the ones the core saw at this edge
        @(posedge clk);
        while (task_stall)
            @(posedge clk);
        pending_outcomes.push_back(predict_queue_outcome(act, item));
    endtask

    task automatic idle_for(input int cycles);
        task_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        task_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PRIORITY_W-1:0] random_priority();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll <= 5)
            return PRIORITY_W'($urandom_range(0, 7));       // dense: many ties
        else if (roll <= 7)
            return PRIORITY_W'($urandom_range(0, 998));
        else if (roll == 8)
            return PRIORITY_W'($urandom_range(999, 1023));  // at or beyond the idle value
        else
            return PRIORITY_W'($urandom_range(0, 1023));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        int drain;
        offer_transaction(ACT_POP, 16'h1234, 32'h5678, 10'd7);           // pop when empty
        offer_transaction(ACT_FINISH, '0, '0, '0);                       // finish while idle
        offer_transaction(ACT_UNUSED, '1, '1, '1);                       // ignored code
        offer_transaction(ACT_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023);
        offer_transaction(ACT_ENQUEUE, 16'h0000, 32'h0000_0000, 10'd0);
        offer_transaction(ACT_ENQUEUE, 16'h00A0, 32'hA5A5_A5A5, 10'd998);
        offer_transaction(ACT_ENQUEUE, 16'h00A1, 32'h5A5A_5A5A, 10'd999);
        // three equal priorities must leave in arrival order
        offer_transaction(ACT_ENQUEUE, 16'h0001, 32'h1111_1111, 10'd500);
        offer_transaction(ACT_ENQUEUE, 16'h0002, 32'h2222_2222, 10'd500);
        offer_transaction(ACT_ENQUEUE, 16'h0003, 32'h3333_3333, 10'd500);
        offer_transaction(ACT_ENQUEUE, 16'h0004, 32'h4444_4444, 10'd0);
        offer_transaction(ACT_ENQUEUE, 16'h0005, 32'h5555_5555, 10'd5);  // store full: dropped
        offer_transaction(ACT_POP, '0, '0, '0);
        offer_transaction(ACT_POP, '0, '0, '0);
        offer_transaction(ACT_POP, '0, '0, '0);                          // now running at 500
        offer_transaction(ACT_ENQUEUE, 16'h0006, 32'h6666_6666, 10'd499); // preempts
        offer_transaction(ACT_ENQUEUE, 16'h0007, 32'h7777_7777, 10'd500); // equal: no preempt
        offer_transaction(ACT_FINISH, '1, '1, '1);
        offer_transaction(ACT_ENQUEUE, 16'h0008, 32'h8888_8888, 10'd0);  // idle: no preempt
        for (drain = 0; drain <= QUEUE_DEPTH; drain++)
            offer_transaction(ACT_POP, '0, '0, '0);                      // drain, then empty pop
    endtask

    task automatic test_random_traffic(input int n_items);
        int             sent;
        int             burst_left;
        int             roll;
        traffic_mix_t   mix;
        logic [ACTION_W-1:0] act;
        sent = 0;
        burst_left = 0;
        mix = MIX_BALANCED;
        while (sent < n_items)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 10));
                if ($urandom_range(0, 5) == 0)
                    mix = traffic_mix_t'($urandom_range(0, 2));
            end
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                    act = (roll < 70) ? ACT_ENQUEUE : (roll < 88) ? ACT_POP :
                          (roll < 96) ? ACT_FINISH : ACT_UNUSED;
                MIX_DRAIN:
                    act = (roll < 25) ? ACT_ENQUEUE : (roll < 85) ? ACT_POP :
                          (roll < 96) ? ACT_FINISH : ACT_UNUSED;
                default:
                    act = (roll < 45) ? ACT_ENQUEUE : (roll < 80) ? ACT_POP :
                          (roll < 96) ? ACT_FINISH : ACT_UNUSED;
            endcase
            offer_transaction(act, HANDLE_W'($urandom_range(0, 16'hFFFF)), $urandom,
                              random_priority());
            if (act != ACT_UNUSED)
                sent++;
            burst_left--;
        end
    endtask

    // Results held off for a long stretch while transactions keep coming, so the
    // core backs up and stalls its input; afterwards the sender waits for a full drain.
    task automatic test_output_backpressure();
        int n;
        hold_requested++;
        for (n = 0; n < 16; n++)
            offer_transaction((n % 3 == 2) ? ACT_POP : ACT_ENQUEUE,
                              HANDLE_W'($urandom_range(0, 16'hFFFF)), $urandom,
                              random_priority());
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern: changes mode each time the 6-bit phase counter wraps; long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == '0)
                stall_mode = $urandom_range(0, 3);
            if (hold_served != hold_requested)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 1) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ((stall_phase % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the model
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                flag_error($sformatf("unexpected result st=%0d h=%0h a=%0h p=%0d pre=%0b",
                           status, popped_handle, popped_argument, popped_priority, preempt));
            end
            else
            begin
                next_expected = pending_outcomes.pop_front();
                if (status !== next_expected.status ||
                    popped_handle !== next_expected.handle ||
                    popped_argument !== next_expected.argument ||
                    popped_priority !== next_expected.prio ||
                    preempt !== next_expected.preempt)
                    flag_error($sformatf({"mismatch exp st=%0d h=%0h a=%0h p=%0d pre=%0b",
                               " got st=%0d h=%0h a=%0h p=%0d pre=%0b"},
                               next_expected.status, next_expected.handle,
                               next_expected.argument, next_expected.prio,
                               next_expected.preempt, status, popped_handle,
                               popped_argument, popped_priority, preempt));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((task_valid && !task_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        task_valid    <= 1'b0;
        action        <= ACT_ENQUEUE;
        task_handle   <= '0;
        task_argument <= '0;
        task_priority <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_for_drain();
        test_random_traffic(200);
        test_output_backpressure();
        test_random_traffic(200);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
